/* hdl/wstd_pkg.sv */
// ----------------------------------------------------------------------------
// Work-stealing task deque package
// Shared request, response and entry types and the operation and status codes.
// ----------------------------------------------------------------------------
package wstd_pkg;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_STEAL = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        opcode_t     opcode;
        logic [63:0] task_handle;
        logic [63:0] payload_word;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [63:0] task_out;
        logic [63:0] payload_out;
    } rsp_t;

    typedef struct packed {
        logic [63:0] task_handle;
        logic [63:0] payload_word;
    } entry_t;

    typedef struct packed {
        status_t status;
        logic    wr_en;
        logic    rd_en;
        logic    pass;
    } ptr_op_t;

endpackage

/* hdl/wstd_ptr.sv */
// ----------------------------------------------------------------------------
// Deque pointer control
// Holds the top and bottom counters, decides each request and gives the
// store slot to write or read.
// ----------------------------------------------------------------------------
module wstd_ptr #(
    parameter int ENTRIES = 256
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  wstd_pkg::opcode_t          opcode,
    output wstd_pkg::ptr_op_t          op,
    output logic [$clog2(ENTRIES)-1:0] wr_idx,
    output logic [$clog2(ENTRIES)-1:0] rd_idx
);

    localparam int CW = $clog2(2 * ENTRIES);
    localparam int IW = $clog2(ENTRIES);
    localparam logic [CW-1:0] CNT_MAX = CW'(2 * ENTRIES - 1);
    localparam logic [CW-1:0] ENT     = CW'(ENTRIES);
    localparam logic [CW:0]   SPAN    = (CW + 1)'(2 * ENTRIES);

    logic [CW-1:0] top_reg;
    logic [CW-1:0] top_next;
    logic [CW-1:0] bottom_reg;
    logic [CW-1:0] bottom_next;
    logic [CW:0]   used_wide;
    logic [CW-1:0] used;
    logic [CW-1:0] last;

    function automatic logic [CW-1:0] bump(input logic [CW-1:0] c);
        return (c == CNT_MAX) ? '0 : c + 1'b1;
    endfunction

    function automatic logic [IW-1:0] slot_of(input logic [CW-1:0] c);
        logic [CW-1:0] d;
        d = (c >= ENT) ? c - ENT : c;
        return d[IW-1:0];
    endfunction

    always_comb
    begin
        used_wide = {1'b0, bottom_reg} - {1'b0, top_reg}
                  + ((bottom_reg < top_reg) ? SPAN : '0);
        used      = used_wide[CW-1:0];
        last      = (bottom_reg == '0) ? CNT_MAX : bottom_reg - 1'b1;
    end

    always_comb
    begin
        op          = '{status: wstd_pkg::ST_EMPTY, wr_en: 1'b0, rd_en: 1'b0, pass: 1'b0};
        top_next    = top_reg;
        bottom_next = bottom_reg;
        wr_idx      = slot_of(bottom_reg);
        rd_idx      = slot_of(top_reg);
        case (opcode)
            wstd_pkg::OP_PUSH:
            begin
                if (used == ENT)
                begin
                    op.status = wstd_pkg::ST_FULL;
                    op.pass   = 1'b1;
                end
                else
                begin
                    op.status   = wstd_pkg::ST_OK;
                    op.wr_en    = 1'b1;
                    bottom_next = bump(bottom_reg);
                end
            end
            wstd_pkg::OP_POP:
            begin
                rd_idx = slot_of(last);
                if (used != '0)
                begin
                    op.status = wstd_pkg::ST_OK;
                    op.rd_en  = 1'b1;
                    if (used == CW'(1))
                        top_next = bump(top_reg);
                    else
                        bottom_next = last;
                end
            end
            wstd_pkg::OP_STEAL:
            begin
                if (used != '0)
                begin
                    op.status = wstd_pkg::ST_OK;
                    op.rd_en  = 1'b1;
                    top_next  = bump(top_reg);
                end
            end
            default:
            begin
                op.status = wstd_pkg::ST_EMPTY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg    <= '0;
            bottom_reg <= '0;
        end
        else if (step)
        begin
            top_reg    <= top_next;
            bottom_reg <= bottom_next;
        end
    end

    a_used_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        used <= ENT)
        else $error("Occupancy exceeds the deque depth.");

    a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(op.wr_en && op.rd_en))
        else $error("Write and read decided for the same request.");

    a_full_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        step && opcode == wstd_pkg::OP_PUSH && used == ENT |=> $stable(bottom_reg))
        else $error("Bottom pointer moved on a rejected push.");

endmodule

/* hdl/work_stealing_task_deque_core.sv */
// ----------------------------------------------------------------------------
// Work-stealing task deque core
// Ring buffer deque: push and pop at the bottom, steal at the top, one
// response beat per request.
// A request is registered in the read stage, then in the response register.
// Throughput: one request per cycle while response beats are taken; a stalled
// response beat lets one more request in and then holds req_ready low.
// Reset clears the top and bottom pointers; the store itself is not cleared.
// ----------------------------------------------------------------------------
module work_stealing_task_deque_core #(
    parameter int ENTRIES = 256
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  wstd_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output wstd_pkg::rsp_t  rsp
);

    localparam int IW = $clog2(ENTRIES);

    wstd_pkg::entry_t  mem [ENTRIES];
    wstd_pkg::entry_t  rd_data_reg;
    wstd_pkg::ptr_op_t op;
    logic [IW-1:0]     wr_idx;
    logic [IW-1:0]     rd_idx;
    logic              accept;
    logic              s1_adv;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    wstd_pkg::status_t s1_status_reg;
    logic              s1_use_mem_reg;
    wstd_pkg::entry_t  s1_data_reg;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    wstd_pkg::rsp_t    rsp_reg;
    wstd_pkg::rsp_t    rsp_next;

    wstd_ptr #(
        .ENTRIES (ENTRIES)
    ) u_ptr (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (accept),
        .opcode (req.opcode),
        .op     (op),
        .wr_idx (wr_idx),
        .rd_idx (rd_idx)
    );

    assign s1_adv    = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !s1_valid_reg || s1_adv;
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk)
    begin
        if (accept && op.wr_en)
            mem[wr_idx] <= '{task_handle: req.task_handle, payload_word: req.payload_word};
        if (accept && op.rd_en)
            rd_data_reg <= mem[rd_idx];
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;

        rsp_valid_next = rsp_valid_reg;
        if (s1_adv)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;

        rsp_next.status      = s1_status_reg;
        rsp_next.task_out    = s1_use_mem_reg ? rd_data_reg.task_handle : s1_data_reg.task_handle;
        rsp_next.payload_out = s1_use_mem_reg ? rd_data_reg.payload_word
                                              : s1_data_reg.payload_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_status_reg  <= op.status;
            s1_use_mem_reg <= op.rd_en;
            if (op.pass)
                s1_data_reg <= '{task_handle: req.task_handle, payload_word: req.payload_word};
            else
                s1_data_reg <= '0;
        end
        if (s1_adv)
            rsp_reg <= rsp_next;
    end

    a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg && $stable(s1_status_reg))
        else $error("Pending beat in the read stage was lost while stalled.");

    a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> req_ready)
        else $error("Request refused with an empty read stage.");

    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> rsp_valid_reg)
        else $error("Advanced beat did not reach the response register.");

endmodule
